/* src/lfu_pkg.sv */
// shared types and constants for the lfu cache table
package lfu_pkg;

  localparam int Entries   = 16;
  localparam int CountBits = 16;
  localparam int IdxBits   = 4;
  localparam int RankBits  = 4;
  localparam int KeyBits   = 32;
  localparam int ValBits   = 32;
  localparam int CapBits   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_UPDATE,
    ST_RESULT
  } lfu_state_e;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } lfu_func_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic evict;
    logic update;
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic full;
  } lfu_sts_t;

endpackage

/* src/lfu_ctrl.sv */
// controller state machine of the lfu cache table
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  lfu_sts_t sts_i,
  output lfu_cmd_t cmd_o
);

  lfu_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_EVICT;
      ST_EVICT:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      // eviction only on a miss into a full table
      ST_EVICT:  cmd_o.evict  = sts_i.full && !sts_i.hit;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_RESULT: out_valid_o  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result beat only follows an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_o.update)) else $error("result without update");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.lookup) else $error("load not followed by lookup");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

endmodule

/* src/lfu_dp.sv */
// datapath of the lfu cache table: entry storage, match, victim and rank update
module lfu_dp import lfu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfu_cmd_t            cmd_i,
  output lfu_sts_t            sts_o,
  input  logic                cfg_we_i,
  input  logic [CapBits-1:0]  cfg_wdata_i,
  input  logic                func_i,
  input  logic [KeyBits-1:0]  key_i,
  input  logic [ValBits-1:0]  value_i,
  output logic                found_o,
  output logic [ValBits-1:0]  read_value_o
);

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [Entries-1:0]  valid_q;
  logic [KeyBits-1:0]  key_q   [Entries];
  logic [ValBits-1:0]  val_q   [Entries];
  logic [CountBits-1:0] cnt_q  [Entries];
  logic [RankBits-1:0] rank_q  [Entries];

  logic [CapBits-1:0]  cap_q;
  logic                func_q;
  logic [KeyBits-1:0]  in_key_q;
  logic [ValBits-1:0]  in_val_q;
  logic                hit_q;
  logic [IdxBits-1:0]  hit_idx_q;
  logic                full_q;
  logic [ValBits-1:0]  rd_q;

  // match and occupancy, combinational over the lanes
  logic               hit_c;
  logic [IdxBits-1:0] hit_idx_c;
  logic [CapBits-1:0] nvalid_c;
  logic [CapBits-1:0] cap_eff;
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    nvalid_c  = '0;
    for (int i = 0; i < Entries; i++) begin
      if (valid_q[i] && key_q[i] == in_key_q && !hit_c) begin
        hit_c     = 1'b1;
        hit_idx_c = IdxBits'(i);
      end
      nvalid_c = nvalid_c + CapBits'(valid_q[i]);
    end
    cap_eff = cap_q;
    if (cap_q == '0) cap_eff = CapBits'(1);
    if (cap_q > CapBits'(Entries)) cap_eff = CapBits'(Entries);
  end

  // victim: lowest count, oldest rank among ties (pairwise dominance)
  logic [Entries-1:0] vic_c;
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      vic_c[i] = valid_q[i];
      for (int j = 0; j < Entries; j++) begin
        if (j != i && valid_q[j] && (cnt_q[j] < cnt_q[i] ||
            (cnt_q[j] == cnt_q[i] && rank_q[j] > rank_q[i])))
          vic_c[i] = 1'b0;
      end
    end
  end

  // first free slot
  logic               free_c;
  logic [IdxBits-1:0] free_idx_c;
  always_comb begin
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = 0; i < Entries; i++) begin
      if (!valid_q[i] && !free_c) begin
        free_c     = 1'b1;
        free_idx_c = IdxBits'(i);
      end
    end
  end

  logic [RankBits-1:0] hit_rank;
  assign hit_rank = rank_q[hit_idx_q];

  // control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cap_q   <= CapBits'(Entries);
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.evict && func_q == FUNC_PUT && !hit_q && full_q) begin
        for (int i = 0; i < Entries; i++) begin
          if (vic_c[i]) valid_q[i] <= 1'b0;
        end
      end
      if (cmd_i.update && func_q == FUNC_PUT && !hit_q && free_c) begin
        valid_q[free_idx_c] <= 1'b1;
      end
    end
  end

  // entry payload and per-beat registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_i;
      in_key_q <= key_i;
      in_val_q <= value_i;
    end
    if (cmd_i.lookup) begin
      hit_q     <= hit_c;
      hit_idx_q <= hit_idx_c;
      full_q    <= nvalid_c >= cap_eff;
      rd_q      <= (hit_c && func_q == FUNC_GET) ? val_q[hit_idx_c] : '1;
    end
    // close the rank gap left by the victim
    if (cmd_i.evict && func_q == FUNC_PUT && !hit_q && full_q) begin
      for (int i = 0; i < Entries; i++) begin
        for (int v = 0; v < Entries; v++) begin
          if (vic_c[v] && valid_q[i] && rank_q[i] > rank_q[v])
            rank_q[i] <= rank_q[i] - RankBits'(1);
        end
      end
    end
    if (cmd_i.update) begin
      if (hit_q) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && IdxBits'(i) != hit_idx_q && rank_q[i] < hit_rank)
            rank_q[i] <= rank_q[i] + RankBits'(1);
        end
        rank_q[hit_idx_q] <= '0;
        if (cnt_q[hit_idx_q] != CountMax)
          cnt_q[hit_idx_q] <= cnt_q[hit_idx_q] + CountBits'(1);
        if (func_q == FUNC_PUT) val_q[hit_idx_q] <= in_val_q;
      end else if (func_q == FUNC_PUT && free_c) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i]) rank_q[i] <= rank_q[i] + RankBits'(1);
        end
        key_q[free_idx_c]  <= in_key_q;
        val_q[free_idx_c]  <= in_val_q;
        cnt_q[free_idx_c]  <= CountBits'(1);
        rank_q[free_idx_c] <= '0;
      end
    end
  end

  assign sts_o.hit    = hit_q;
  assign sts_o.full   = full_q;
  assign found_o      = hit_q;
  assign read_value_o = rd_q;

  // at most one victim and it is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> $onehot0(vic_c)) else $error("several victims");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.evict && valid_q != '0) |-> $onehot(vic_c)) else $error("no victim");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && func_q == FUNC_PUT && !hit_q) |-> free_c)
    else $error("no free slot for insert");

endmodule

/* src/lfu_cache_table_unit.sv */
// top level of the lfu cache table
// Fully associative 16-entry key-value cache, lfu replacement with lru tie
// break. A beat is accepted in the idle state; lookup, evict and update then
// follow as separate states, and the result is presented in the result state
// and held until the receiver takes it. The next beat can be accepted only
// after the result leaves and the controller is back in idle, so a beat is
// not taken while another is in flight; an output stall lengthens its stay.
// The rate is set by the single table update path the controller steps through.
module lfu_cache_table_unit import lfu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we,
  input  logic [CapBits-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic [ValBits-1:0] value_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found_o,
  output logic [ValBits-1:0] read_value_o
);

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  // controller
  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sts_i(sts), .cmd_o(cmd)
  );

  // datapath
  lfu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata), .func_i, .key_i, .value_i,
    .found_o, .read_value_o
  );

endmodule

/* dv/lfu_cache_table_unit_tb.sv */
// testbench for the lfu cache table: directed and random get/put traffic against a predictor
`timescale 1ns / 100ps

module lfu_cache_table_unit_tb;
  import lfu_pkg::*;

  typedef struct packed {
    logic               found;
    logic [ValBits-1:0] read_value;
  } lookup_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CapBits-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func_i = 1'b0;
  logic [KeyBits-1:0] key_i = '0;
  logic [ValBits-1:0] value_i = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found_o;
  logic [ValBits-1:0] read_value_o;

  // predictor state
  logic                 pr_valid [Entries];
  logic [KeyBits-1:0]   pr_key   [Entries];
  logic [ValBits-1:0]   pr_val   [Entries];
  logic [CountBits-1:0] pr_count [Entries];
  int unsigned          pr_rank  [Entries];
  logic [CapBits-1:0]   pr_cap;

  lookup_res_t expected_q [$];
  int  mismatches = 0;
  bit  idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  lfu_cache_table_unit i_dut (
    .clk_i, .rst_ni, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .func_i,
    .key_i, .value_i, .out_valid, .out_stall, .found_o, .read_value_o
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // make entry the most recent and count one use
  task automatic touch_slot(int s);
    for (int j = 0; j < Entries; j++)
      if (pr_valid[j] && j != s && pr_rank[j] < pr_rank[s]) pr_rank[j]++;
    pr_rank[s] = 0;
    if (pr_count[s] != '1) pr_count[s]++;
  endtask

  // lfu victim with lru tie break
  task automatic evict_victim();
    int v;
    v = -1;
    for (int i = 0; i < Entries; i++)
      if (pr_valid[i] && (v < 0 || pr_count[i] < pr_count[v] ||
          (pr_count[i] == pr_count[v] && pr_rank[i] > pr_rank[v]))) v = i;
    if (v >= 0) begin
      pr_valid[v] = 1'b0;
      for (int i = 0; i < Entries; i++)
        if (pr_valid[i] && pr_rank[i] > pr_rank[v]) pr_rank[i]--;
    end
  endtask

  function automatic int find_slot(logic [KeyBits-1:0] k);
    for (int i = 0; i < Entries; i++)
      if (pr_valid[i] && pr_key[i] == k) return i;
    return -1;
  endfunction

  // cache predictor: one result per beat
  task automatic predict_lookup(lfu_func_e f, logic [KeyBits-1:0] k,
                                logic [ValBits-1:0] v);
    int s, n, cap;
    lookup_res_t r;
    cap = (pr_cap == 0) ? 1 : ((pr_cap > Entries) ? Entries : pr_cap);
    s = find_slot(k);
    r.found = (s >= 0);
    r.read_value = '1;
    if (f == FUNC_GET) begin
      if (s >= 0) begin
        touch_slot(s);
        r.read_value = pr_val[s];
      end
    end else if (s >= 0) begin
      pr_val[s] = v;
      touch_slot(s);
    end else begin
      n = 0;
      foreach (pr_valid[i]) if (pr_valid[i]) n++;
      if (n >= cap) evict_victim();
      s = -1;
      for (int i = Entries - 1; i >= 0; i--) if (!pr_valid[i]) s = i;
      if (s >= 0) begin
        foreach (pr_valid[i]) if (pr_valid[i]) pr_rank[i]++;
        pr_valid[s] = 1'b1;
        pr_key[s]   = k;
        pr_val[s]   = v;
        pr_count[s] = 1;
        pr_rank[s]  = 0;
      end
    end
    expected_q.push_back(r);
  endtask

  // send one beat; valid stays high into the next beat unless an idle cycle is drawn
  task automatic send_beat(lfu_func_e f, logic [KeyBits-1:0] k, logic [ValBits-1:0] v);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    func_i   <= f;
    key_i    <= k;
    value_i  <= v;
    in_valid <= 1'b1;
    predict_lookup(f, k, v);
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CapBits-1:0] c);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pr_cap = c;
  endtask

  // receiver stall
  always @(posedge clk_i)
    out_stall <= rx_idle_on && ($urandom_range(99) < 10);

  // result checker
  always @(posedge clk_i) begin
    lookup_res_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result found=%0b val=%h",
                                       found_o, read_value_o);
      end else begin
        e = expected_q.pop_front();
        if (e.found !== found_o || e.read_value !== read_value_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0b val=%h, got found=%0b val=%h",
                     e.found, e.read_value, found_o, read_value_o);
        end
      end
    end
  end

  // extreme keys, values, hits, misses and count ties
  task automatic test_directed();
    send_beat(FUNC_GET, 32'h0, 32'h0);
    send_beat(FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(FUNC_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(FUNC_PUT, 32'h0, 32'h0);
    send_beat(FUNC_GET, 32'h8000_0000, 32'h1234_5678);
    send_beat(FUNC_GET, 32'h7fff_ffff, 32'h0);
    send_beat(FUNC_PUT, 32'h7fff_ffff, 32'h5555_aaaa);
    send_beat(FUNC_GET, 32'h7fff_ffff, 32'h0);
    send_beat(FUNC_GET, 32'h1, 32'h0);
    for (int i = 0; i < 14; i++) send_beat(FUNC_PUT, 32'h100 + i, i);
  endtask

  // capacity one, zero and above the table size, and lowered capacity below occupancy
  task automatic test_capacity_edges();
    write_capacity(5'd1);
    send_beat(FUNC_PUT, 32'h2000, 32'h1);
    send_beat(FUNC_PUT, 32'h2001, 32'h2);
    send_beat(FUNC_GET, 32'h2000, 32'h0);
    send_beat(FUNC_GET, 32'h2001, 32'h0);
    write_capacity(5'd16);
    for (int i = 0; i < 16; i++) send_beat(FUNC_PUT, 32'h3000 + i, i);
    write_capacity(5'd4);
    send_beat(FUNC_PUT, 32'h4000, 32'h4);
    send_beat(FUNC_GET, 32'h3005, 32'h0);
    write_capacity(5'd0);
    send_beat(FUNC_PUT, 32'h4001, 32'h5);
    write_capacity(5'd31);
    send_beat(FUNC_PUT, 32'h4002, 32'h6);
  endtask

  // one hot key used many times stays resident through a flood of inserts
  task automatic test_count_saturation();
    write_capacity(5'd16);
    send_beat(FUNC_PUT, 32'hdead, 32'h1);
    idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < 30; i++) send_beat(FUNC_GET, 32'hdead, 32'h0);
    idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_beat(FUNC_PUT, 32'hdead, 32'h2);
    for (int i = 0; i < 20; i++) send_beat(FUNC_PUT, 32'h5000 + i, i);
    send_beat(FUNC_GET, 32'hdead, 32'h0);
  endtask

  // random traffic over a small key pool, several capacities
  task automatic test_random();
    logic [KeyBits-1:0] k;
    for (int phase = 0; phase < 5; phase++) begin
      write_capacity((phase == 0) ? 5'd16 : CapBits'($urandom_range(1, 16)));
      idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(9) == 0) k = $urandom;
        else k = 32'hc000_0000 ^ $urandom_range(23);
        send_beat($urandom_range(1) ? FUNC_PUT : FUNC_GET, k, $urandom);
        if (phase == 3 && i == 80) drain_results();
      end
    end
    idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    foreach (pr_valid[i]) begin
      pr_valid[i] = 1'b0; pr_key[i] = '0; pr_val[i] = '0;
      pr_count[i] = '0; pr_rank[i] = 0;
    end
    pr_cap = 5'd16;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_capacity_edges();
    test_count_saturation();
    test_random();
    drain_results();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("lfu_cache_table_unit test passed");
    else
      $display("lfu_cache_table_unit test failed");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("lfu_cache_table_unit test failed");
    $finish;
  end

endmodule
